FILE: rtl/dcr_pkg.sv
// Shared types, constants and helper functions for the disc pair collision block.
`timescale 1ns / 1ps

package dcr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIRST_MASS  = 2'd0;
  localparam logic [1:0] CFG_SECOND_MASS = 2'd1;
  localparam logic [1:0] CFG_RESTITUTION = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Quotient widths of the three divider chains.
  localparam int unsigned QB_W = 35;
  localparam int unsigned QV_W = 32;
  localparam int unsigned QU_W = 36;

  localparam int unsigned FRONT_LAT = 4;
  localparam int unsigned AXIS_LAT  = 6 + QB_W + QU_W;

  localparam int unsigned SUM_W = 56;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] first_vx;
    logic signed [31:0] first_vy;
    logic signed [31:0] second_vx;
    logic signed [31:0] second_vy;
    logic [30:0]        first_radius;
    logic [30:0]        second_radius;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_first_vx;
    logic signed [31:0] out_first_vy;
    logic signed [31:0] out_second_vx;
    logic signed [31:0] out_second_vy;
    logic               touching;
    logic               bounced;
  } out_word_t;

  typedef struct packed {
    logic signed [32:0] dc;
    logic signed [32:0] dvc;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
  } axis_in_t;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n : v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7fffffff);
    lo = -SUM_W'(33'sh080000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: rtl/dcr_pipe.sv
// Delay line of enabled registers that keeps side data aligned with the datapath.
`timescale 1ns / 1ps

module dcr_pipe #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

FILE: rtl/dcr_div.sv
// Pipelined restoring divider that settles one quotient bit per stage.
`timescale 1ns / 1ps

module dcr_div #(
  parameter int unsigned N_W = 99,
  parameter int unsigned D_W = 66,
  parameter int unsigned Q_W = 35
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [Q_W-1:0] quo_o
);

  logic [D_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0] low_q [Q_W];
  logic [Q_W-1:0] quo_q [Q_W];
  logic [D_W-1:0] den_q [Q_W];
  logic [N_W-1:0] num_sh;

  // The caller guarantees the quotient fits, so the upper part is below the divisor.
  assign num_sh = num_i >> Q_W;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W-1:0] rem_in;
    logic [D_W-1:0] den_in;
    logic [Q_W-1:0] low_in;
    logic [Q_W-1:0] quo_in;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = num_sh[D_W-1:0];
      assign low_in = num_i[Q_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        low_q[k] <= low_in << 1;
        quo_q[k] <= {quo_in[Q_W-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

FILE: rtl/dcr_front.sv
// Front stages: offsets, squared distance, contact test and the approach dot product.
`timescale 1ns / 1ps

module dcr_front (
  input  logic             clk_i,
  input  logic             en_i,
  input  dcr_pkg::in_word_t in_word_i,
  output dcr_pkg::axis_in_t ax_x_o,
  output dcr_pkg::axis_in_t ax_y_o,
  output logic [65:0]      dot_o,
  output logic [65:0]      dd_o,
  output logic             touching_o,
  output logic             bounced_o
);

  import dcr_pkg::*;

  in_word_t s1_q;

  axis_in_t    s2_x_q, s2_y_q;
  logic [31:0] s2_rsum_q;

  axis_in_t    s3_x_q, s3_y_q;
  logic [65:0] s3_dx2_q, s3_dy2_q, s3_ta_q, s3_tb_q;
  logic [63:0] s3_rr_q;
  logic        s3_na_q, s3_nb_q;

  logic [32:0] dxm, dym, dvxm, dvym;
  logic [65:0] dd_d, dot_d;
  logic        dneg_d, touch_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_x_q.dc  <= 33'(s1_q.second_x) - 33'(s1_q.first_x);
      s2_x_q.dvc <= 33'(s1_q.second_vx) - 33'(s1_q.first_vx);
      s2_x_q.v1  <= s1_q.first_vx;
      s2_x_q.v2  <= s1_q.second_vx;
      s2_y_q.dc  <= 33'(s1_q.second_y) - 33'(s1_q.first_y);
      s2_y_q.dvc <= 33'(s1_q.second_vy) - 33'(s1_q.first_vy);
      s2_y_q.v1  <= s1_q.first_vy;
      s2_y_q.v2  <= s1_q.second_vy;
      s2_rsum_q  <= 32'(s1_q.first_radius) + 32'(s1_q.second_radius);
    end
  end

  assign dxm  = mag33(s2_x_q.dc);
  assign dym  = mag33(s2_y_q.dc);
  assign dvxm = mag33(s2_x_q.dvc);
  assign dvym = mag33(s2_y_q.dvc);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_x_q   <= s2_x_q;
      s3_y_q   <= s2_y_q;
      s3_dx2_q <= 66'(dxm) * 66'(dxm);
      s3_dy2_q <= 66'(dym) * 66'(dym);
      s3_ta_q  <= 66'(dvxm) * 66'(dxm);
      s3_tb_q  <= 66'(dvym) * 66'(dym);
      s3_rr_q  <= 64'(s2_rsum_q) * 64'(s2_rsum_q);
      s3_na_q  <= s2_x_q.dvc[32] != s2_x_q.dc[32];
      s3_nb_q  <= s2_y_q.dvc[32] != s2_y_q.dc[32];
    end
  end

  always_comb begin
    dd_d    = s3_dx2_q + s3_dy2_q;
    touch_d = dd_d < {2'b00, s3_rr_q};
    if (s3_na_q == s3_nb_q) begin
      dot_d  = s3_ta_q + s3_tb_q;
      dneg_d = s3_na_q;
    end else if (s3_ta_q >= s3_tb_q) begin
      dot_d  = s3_ta_q - s3_tb_q;
      dneg_d = s3_na_q;
    end else begin
      dot_d  = s3_tb_q - s3_ta_q;
      dneg_d = s3_nb_q;
    end
    if (dot_d == '0) begin
      dneg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_x_o     <= s3_x_q;
      ax_y_o     <= s3_y_q;
      dot_o      <= dot_d;
      dd_o       <= dd_d;
      touching_o <= touch_d;
      bounced_o  <= touch_d & dneg_d;
    end
  end

endmodule

FILE: rtl/dcr_axis.sv
// Per-axis response: reflection quotient, mass split, restitution scaling and saturation.
`timescale 1ns / 1ps

module dcr_axis #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  dcr_pkg::axis_in_t  ax_i,
  input  logic [65:0]        dot_i,
  input  logic [65:0]        dd_i,
  input  logic               bounced_i,
  input  logic [15:0]        ma_i,
  input  logic [15:0]        mb_i,
  input  logic [16:0]        tot_i,
  input  logic [16:0]        rest_i,
  output logic signed [31:0] res1_o,
  output logic signed [31:0] res2_o
);

  import dcr_pkg::*;

  localparam int unsigned DD_DLY   = 2;
  localparam int unsigned DVC_DLY  = 2 + QB_W;
  localparam int unsigned VM_DLY   = QB_W + QU_W + 3 - QV_W;
  localparam int unsigned VN_DLY   = QB_W + QU_W + 3;
  localparam int unsigned WN_DLY   = QU_W + 1;
  localparam int unsigned PASS_DLY = QB_W + QU_W + 5;

  logic [32:0] dcm;
  logic        pos;

  logic [64:0]        plo_q;
  logic [66:0]        phi_q;
  logic signed [48:0] pva_q, pvb_q;

  logic [98:0]        num_q;
  logic signed [49:0] vsum;
  logic signed [49:0] vsum_n;
  logic               vneg_q;
  logic [48:0]        vmag_q;

  logic [65:0]     dd_d;
  logic [QB_W-1:0] qb;
  logic [QV_W-1:0] qv;
  logic [QV_W-1:0] vmag_d;
  logic            vneg_d;

  logic [33:0]        sd_in, sd_out;
  logic               pos_d;
  logic signed [32:0] dvc_d;

  logic signed [36:0] w_q;
  logic signed [36:0] w_n;
  logic [35:0]        wm;
  logic [51:0]        pu1_q, pu2_q;
  logic               wneg_q, wneg_d;
  logic [QU_W-1:0]    u1, u2;

  logic [52:0] e1_q, e2_q;

  logic [64:0]        pass_in, pass_out;
  logic               bnc_d;
  logic signed [31:0] v1_d, v2_d;

  logic signed [SUM_W-1:0] vcm_s, se1, se2, sum1, sum2;
  logic [52:0]             e1m, e2m;

  assign dcm = mag33(ax_i.dc);
  assign pos = !ax_i.dc[32] && (ax_i.dc != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= 65'(dot_i[31:0]) * 65'(dcm);
      phi_q <= 67'(dot_i[65:32]) * 67'(dcm);
      pva_q <= 49'($signed({1'b0, ma_i})) * 49'(ax_i.v1);
      pvb_q <= 49'($signed({1'b0, mb_i})) * 49'(ax_i.v2);
    end
  end

  assign vsum   = 50'(pva_q) + 50'(pvb_q);
  assign vsum_n = -vsum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= (99'({phi_q, 32'd0}) + 99'(plo_q)) << 1;
      vneg_q <= vsum[49];
      vmag_q <= vsum[49] ? vsum_n[48:0] : vsum[48:0];
    end
  end

  dcr_pipe #(.W(66), .DEPTH(DD_DLY)) u_dd_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(dd_i), .q_o(dd_d)
  );

  dcr_div #(.N_W(99), .D_W(66), .Q_W(QB_W)) u_div_refl (
    .clk_i(clk_i), .en_i(en_i), .num_i(num_q), .den_i(dd_d), .quo_o(qb)
  );

  dcr_div #(.N_W(49), .D_W(17), .Q_W(QV_W)) u_div_vcm (
    .clk_i(clk_i), .en_i(en_i), .num_i(vmag_q), .den_i(tot_i), .quo_o(qv)
  );

  dcr_pipe #(.W(QV_W), .DEPTH(VM_DLY)) u_vm_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(qv), .q_o(vmag_d)
  );

  dcr_pipe #(.W(1), .DEPTH(VN_DLY)) u_vn_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(vneg_q), .q_o(vneg_d)
  );

  assign sd_in = {pos, ax_i.dvc};

  dcr_pipe #(.W(34), .DEPTH(DVC_DLY)) u_dvc_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(sd_in), .q_o(sd_out)
  );

  assign pos_d = sd_out[33];
  assign dvc_d = sd_out[32:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= 37'(dvc_d) + (pos_d ? $signed({2'b00, qb}) : -$signed({2'b00, qb}));
    end
  end

  assign w_n = -w_q;
  assign wm  = w_q[36] ? w_n[35:0] : w_q[35:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pu1_q  <= 52'(mb_i) * 52'(wm);
      pu2_q  <= 52'(ma_i) * 52'(wm);
      wneg_q <= w_q[36];
    end
  end

  dcr_div #(.N_W(52), .D_W(17), .Q_W(QU_W)) u_div_u1 (
    .clk_i(clk_i), .en_i(en_i), .num_i(pu1_q), .den_i(tot_i), .quo_o(u1)
  );

  dcr_div #(.N_W(52), .D_W(17), .Q_W(QU_W)) u_div_u2 (
    .clk_i(clk_i), .en_i(en_i), .num_i(pu2_q), .den_i(tot_i), .quo_o(u2)
  );

  dcr_pipe #(.W(1), .DEPTH(WN_DLY)) u_wn_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(wneg_q), .q_o(wneg_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q <= 53'(rest_i) * 53'(u1);
      e2_q <= 53'(rest_i) * 53'(u2);
    end
  end

  assign pass_in = {bounced_i, ax_i.v1, ax_i.v2};

  dcr_pipe #(.W(65), .DEPTH(PASS_DLY)) u_pass_dly (
    .clk_i(clk_i), .en_i(en_i), .d_i(pass_in), .q_o(pass_out)
  );

  assign bnc_d = pass_out[64];
  assign v1_d  = pass_out[63:32];
  assign v2_d  = pass_out[31:0];

  always_comb begin
    e1m   = e1_q >> FRAC_BITS;
    e2m   = e2_q >> FRAC_BITS;
    vcm_s = vneg_d ? -$signed(SUM_W'(vmag_d)) : $signed(SUM_W'(vmag_d));
    se1   = wneg_d ? -$signed(SUM_W'(e1m)) : $signed(SUM_W'(e1m));
    se2   = wneg_d ? -$signed(SUM_W'(e2m)) : $signed(SUM_W'(e2m));
    sum1  = vcm_s - se1;
    sum2  = vcm_s + se2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res1_o <= bnc_d ? sat32(sum1) : v1_d;
      res2_o <= bnc_d ? sat32(sum2) : v2_d;
    end
  end

endmodule

FILE: rtl/disc_pair_collision_response.sv
// Top level of the disc pair collision response pipeline.
`timescale 1ns / 1ps

// Takes one pair of discs per clock and returns the updated velocities together with
// the touching and bounced flags. Four front stages compute offsets, squares and
// the dot product; per axis a 35-stage divider then forms the reflection quotient
// and two 36-stage dividers the mass split, each settling one quotient bit per
// stage. A new word can enter every cycle; a held output result stalls the whole
// pipeline until it is taken. The user must write masses and restitution through the
// configuration port while no word is in flight; the block does not enforce this.
module disc_pair_collision_response #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dcr_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dcr_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [dcr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dcr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import dcr_pkg::*;

  localparam int unsigned TOT_LAT = FRONT_LAT + AXIS_LAT;

  logic [15:0] first_mass_q, second_mass_q;
  logic [16:0] restitution_q;
  logic [15:0] ma, mb;
  logic [16:0] tot;

  logic [TOT_LAT-1:0] vld_q;
  logic               en;

  axis_in_t    ax_x, ax_y;
  logic [65:0] dot, dd;
  logic        touching, bounced, touch_d, bounced_d;

  logic signed [31:0] first_vx, first_vy, second_vx, second_vy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_mass_q  <= 16'd10;
      second_mass_q <= 16'd10;
      restitution_q <= 17'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_MASS:  first_mass_q  <= cfg_data_i[15:0];
        CFG_SECOND_MASS: second_mass_q <= cfg_data_i[15:0];
        CFG_RESTITUTION: restitution_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A mass of zero is treated as one.
  assign ma  = (first_mass_q == '0) ? 16'd1 : first_mass_q;
  assign mb  = (second_mass_q == '0) ? 16'd1 : second_mass_q;
  assign tot = 17'(ma) + 17'(mb);

  assign en         = !(vld_q[TOT_LAT-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[TOT_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT_LAT-2:0], in_valid_i};
    end
  end

  dcr_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .in_word_i  (in_word_i),
    .ax_x_o     (ax_x),
    .ax_y_o     (ax_y),
    .dot_o      (dot),
    .dd_o       (dd),
    .touching_o (touching),
    .bounced_o  (bounced)
  );

  dcr_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .ax_i      (ax_x),
    .dot_i     (dot),
    .dd_i      (dd),
    .bounced_i (bounced),
    .ma_i      (ma),
    .mb_i      (mb),
    .tot_i     (tot),
    .rest_i    (restitution_q),
    .res1_o    (first_vx),
    .res2_o    (second_vx)
  );

  dcr_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .ax_i      (ax_y),
    .dot_i     (dot),
    .dd_i      (dd),
    .bounced_i (bounced),
    .ma_i      (ma),
    .mb_i      (mb),
    .tot_i     (tot),
    .rest_i    (restitution_q),
    .res1_o    (first_vy),
    .res2_o    (second_vy)
  );

  dcr_pipe #(.W(1), .DEPTH(AXIS_LAT)) u_touch_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (touching),
    .q_o   (touch_d)
  );

  dcr_pipe #(.W(1), .DEPTH(AXIS_LAT)) u_bounce_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (bounced),
    .q_o   (bounced_d)
  );

  assign out_word_o = '{first_vx, first_vy, second_vx, second_vy, touch_d, bounced_d};

endmodule
